### rtl/assert_macros.svh
// Assertion macros used by the table core.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check prop at every rising edge of clk while rst is low.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Check prop at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/cbat_pkg.sv
package cbat_pkg;

   localparam int CLIENTS = 64;
   localparam int IDX_W   = $clog2(CLIENTS);
   localparam int CNT_W   = $clog2(CLIENTS + 1);
   localparam int VAL_W   = 48;
   localparam int ACT_W   = 16;
   localparam int ALU_W   = VAL_W + 2;
   localparam int IDLE_W  = VAL_W + 1;

   localparam logic [1:0] REQ_RESERVE = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_SWEEP   = 2'd2;

   localparam logic [1:0] STATUS_DONE       = 2'd0;
   localparam logic [1:0] STATUS_EXCEEDED   = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN    = 2'd2;
   localparam logic [1:0] STATUS_SWEEP_DONE = 2'd3;

   localparam logic [1:0] CSR_IDLE_TIMEOUT  = 2'd0;
   localparam logic [1:0] CSR_DEFAULT_CHECK = 2'd1;

   localparam logic [VAL_W-1:0] IDLE_TIMEOUT_RESET  = VAL_W'(24 * 60 * 60 * 1000);
   localparam logic [VAL_W-1:0] DEFAULT_CHECK_RESET = VAL_W'(2 * 60 * 60 * 1000);

   typedef struct packed {
      logic [VAL_W-1:0] capacity;
      logic             unlimited;
      logic [VAL_W-1:0] consumed;
      logic [ACT_W-1:0] active;
      logic [VAL_W-1:0] idle_stamp;
   } entry_type;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

endpackage

### rtl/cbat_ram.sv
module cbat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cbat_alu.sv
module cbat_alu (
   input  cbat_pkg::alu_req_type          req,
   output logic [cbat_pkg::ALU_W-1:0]     result
);

   logic [cbat_pkg::ALU_W-1:0] b_eff;

   // Subtract as a + ~b + 1.
   assign b_eff  = req.sub ? ~req.b : req.b;
   assign result = req.a + b_eff + cbat_pkg::ALU_W'(req.sub);

endmodule

### rtl/client_bandwidth_admission_table_core.sv
// Channel | Handshake             | Payload
// --------+-----------------------+-------------------------------------------------
// req     | req_valid / req_stall | req_type, client_id, capacity, unlimited, bw, now
// rsp     | rsp_valid / rsp_stall | status, consumed, active, capacity, idle, next, count
// csr     | csr_valid / csr_ready | csr_index, csr_wdata
//
// Reserve adds and then compares, release subtracts, an unused code only answers;
// the result register loads as the sequencer returns to idle.
// Sweep reads each entry in turn, skips absent or active ones, removes those
// idle for at least the timeout and tracks the longest idle time of those kept.
// The one shared 50-bit adder and the single RAM read port serve every step.
// req_stall stays high from accept until the result is loaded into the output
// register; the last step holds while rsp_stall holds an earlier result.
// Reset is synchronous: it clears the valid bits and the client count at once.
`include "assert_macros.svh"

module client_bandwidth_admission_table_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_type,
   input  logic [5:0]                     req_client_id,
   input  logic [cbat_pkg::VAL_W-1:0]     req_capacity_bps,
   input  logic                           req_capacity_unlimited,
   input  logic [cbat_pkg::VAL_W-1:0]     req_bandwidth_bps,
   input  logic [cbat_pkg::VAL_W-1:0]     req_now_ms,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [cbat_pkg::VAL_W-1:0]     rsp_consumed_bps,
   output logic [cbat_pkg::ACT_W-1:0]     rsp_active_transfers,
   output logic [cbat_pkg::VAL_W-1:0]     rsp_client_capacity_bps,
   output logic signed [cbat_pkg::IDLE_W-1:0] rsp_longest_idle_ms,
   output logic [cbat_pkg::VAL_W-1:0]     rsp_next_check_ms,
   output logic [cbat_pkg::CNT_W-1:0]     rsp_client_count,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [1:0]                     csr_index,
   input  logic [cbat_pkg::VAL_W-1:0]     csr_wdata
);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RS_SUM  = 4'd1;
   localparam logic [3:0] ST_RS_CMP  = 4'd2;
   localparam logic [3:0] ST_RL_SUB  = 4'd3;
   localparam logic [3:0] ST_SW_RD   = 4'd4;
   localparam logic [3:0] ST_SW_IDLE = 4'd5;
   localparam logic [3:0] ST_SW_TMO  = 4'd6;
   localparam logic [3:0] ST_SW_MAX  = 4'd7;
   localparam logic [3:0] ST_SW_FIN  = 4'd8;
   localparam logic [3:0] ST_NOP     = 4'd9;

   localparam int VAL_W  = cbat_pkg::VAL_W;
   localparam int ACT_W  = cbat_pkg::ACT_W;
   localparam int ALU_W  = cbat_pkg::ALU_W;
   localparam int IDLE_W = cbat_pkg::IDLE_W;
   localparam int IDX_W  = cbat_pkg::IDX_W;
   localparam int CNT_W  = cbat_pkg::CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(cbat_pkg::CLIENTS - 1);

   // Control state.
   logic [3:0]                    state_ff;
   logic [cbat_pkg::CLIENTS-1:0]  valid_ff;
   logic [CNT_W-1:0]              count_ff;
   logic                          rsp_valid_ff;
   logic [VAL_W-1:0]              tmo_ff;
   logic [VAL_W-1:0]              dflt_ff;

   // Working registers of the transaction in flight.
   logic [IDX_W-1:0]              addr_ff;
   logic [VAL_W-1:0]              cap_ff;
   logic                          unl_ff;
   logic [VAL_W-1:0]              bw_ff;
   logic [VAL_W-1:0]              now_ff;
   logic [VAL_W-1:0]              cons_ff;
   logic [ACT_W-1:0]              act_ff;
   logic [ALU_W-1:0]              acc_ff;
   logic [IDLE_W-1:0]             longest_ff;

   // Output register.
   logic [1:0]                    status_ff;
   logic [VAL_W-1:0]              out_cons_ff;
   logic [ACT_W-1:0]              out_act_ff;
   logic [VAL_W-1:0]              out_cap_ff;
   logic [IDLE_W-1:0]             out_longest_ff;
   logic [VAL_W-1:0]              out_next_ff;
   logic [CNT_W-1:0]              out_count_ff;

   // Table RAM and shared adder.
   cbat_pkg::entry_type           rd_entry;
   cbat_pkg::entry_type           wr_entry;
   logic                          wr_en;
   logic [IDX_W-1:0]              rd_addr;
   cbat_pkg::alu_req_type         alu_req;
   logic [ALU_W-1:0]              alu_res;
   logic                          alu_neg;

   logic                          out_free;
   logic                          rsp_load;
   logic                          cur_valid;
   logic                          rs_grant;
   logic [VAL_W-1:0]              rs_cons;
   logic [ACT_W-1:0]              rs_act;
   logic [VAL_W-1:0]              rl_cons;
   logic [ACT_W-1:0]              rl_act;
   logic [VAL_W-1:0]              rl_stamp;
   logic                          longest_pos;
   logic [IDLE_W-1:0]             sweep_idle;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur_valid = valid_ff[addr_ff];

   // Load the output register from the last step of every transaction.
   assign rsp_load  = out_free &&
                      (state_ff inside {ST_RS_CMP, ST_RL_SUB, ST_SW_FIN, ST_NOP});

   // Read the requested client right at accept; afterwards keep the latched index.
   assign rd_addr = (state_ff == ST_IDLE) ? req_client_id[IDX_W-1:0] : addr_ff;

   cbat_ram #(
      .WIDTH ($bits(cbat_pkg::entry_type)),
      .DEPTH (cbat_pkg::CLIENTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   cbat_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   assign alu_neg = alu_res[ALU_W-1];

   // Steer the shared adder for the current step.
   always_comb begin
      alu_req = '0;
      unique case (state_ff)
         ST_RS_SUM: begin
            alu_req.a = cur_valid ? {2'b00, rd_entry.consumed} : '0;
            alu_req.b = {2'b00, bw_ff};
         end
         ST_RS_CMP: begin
            alu_req.sub = 1'b1;
            alu_req.a   = {2'b00, cap_ff};
            alu_req.b   = acc_ff;
         end
         ST_RL_SUB: begin
            alu_req.sub = 1'b1;
            alu_req.a   = {2'b00, rd_entry.consumed};
            alu_req.b   = {2'b00, bw_ff};
         end
         ST_SW_IDLE: begin
            alu_req.sub = 1'b1;
            alu_req.a   = {2'b00, now_ff};
            alu_req.b   = {2'b00, rd_entry.idle_stamp};
         end
         ST_SW_TMO: begin
            alu_req.sub = 1'b1;
            alu_req.a   = acc_ff;
            alu_req.b   = {2'b00, tmo_ff};
         end
         ST_SW_MAX: begin
            alu_req.sub = 1'b1;
            alu_req.a   = acc_ff;
            alu_req.b   = {longest_ff[IDLE_W-1], longest_ff};
         end
         ST_SW_FIN: begin
            alu_req.sub = 1'b1;
            alu_req.a   = {2'b00, tmo_ff};
            alu_req.b   = {longest_ff[IDLE_W-1], longest_ff};
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   // Reserve: grant when unlimited or when consumed + requested fits the capacity.
   assign rs_grant = unl_ff || !alu_neg;
   assign rs_cons  = !rs_grant ? cons_ff :
                     acc_ff[VAL_W] ? {VAL_W{1'b1}} : acc_ff[VAL_W-1:0];
   assign rs_act   = (!rs_grant || (&act_ff)) ? act_ff : act_ff + ACT_W'(1);

   // Release: saturate count and bandwidth at zero, stamp on going idle.
   assign rl_cons  = alu_neg ? '0 : alu_res[VAL_W-1:0];
   assign rl_act   = (rd_entry.active == '0) ? '0 : rd_entry.active - ACT_W'(1);
   assign rl_stamp = (rl_act == '0) ? now_ff : rd_entry.idle_stamp;

   assign longest_pos = !longest_ff[IDLE_W-1] && (longest_ff != '0);
   assign sweep_idle  = acc_ff[IDLE_W-1:0];

   always_comb begin
      wr_en    = 1'b0;
      wr_entry = rd_entry;
      if (state_ff == ST_RS_CMP && out_free) begin
         wr_en               = 1'b1;
         wr_entry.capacity   = cap_ff;
         wr_entry.unlimited  = unl_ff;
         wr_entry.consumed   = rs_cons;
         wr_entry.active     = rs_act;
         wr_entry.idle_stamp = '0;
      end else if (state_ff == ST_RL_SUB && out_free && cur_valid) begin
         wr_en               = 1'b1;
         wr_entry.consumed   = rl_cons;
         wr_entry.active     = rl_act;
         wr_entry.idle_stamp = rl_stamp;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         tmo_ff       <= cbat_pkg::IDLE_TIMEOUT_RESET;
         dflt_ff      <= cbat_pkg::DEFAULT_CHECK_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               cbat_pkg::CSR_IDLE_TIMEOUT:  tmo_ff  <= csr_wdata;
               cbat_pkg::CSR_DEFAULT_CHECK: dflt_ff <= csr_wdata;
               default: ;
            endcase
         end

         // Load a new result, or drop the one just taken.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff) inside
            ST_IDLE: begin
               if (req_valid) begin
                  case (req_type)
                     cbat_pkg::REQ_RESERVE: state_ff <= ST_RS_SUM;
                     cbat_pkg::REQ_RELEASE: state_ff <= ST_RL_SUB;
                     cbat_pkg::REQ_SWEEP:   state_ff <= ST_SW_RD;
                     default:               state_ff <= ST_NOP;
                  endcase
               end
            end
            ST_RS_SUM: begin
               state_ff <= ST_RS_CMP;
            end
            ST_RS_CMP: begin
               if (out_free) begin
                  valid_ff[addr_ff] <= 1'b1;
                  if (!cur_valid) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_RL_SUB, ST_SW_FIN, ST_NOP: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_SW_RD: begin
               state_ff <= ST_SW_IDLE;
            end
            ST_SW_IDLE: begin
               // Skip absent and active clients.
               if (!cur_valid || rd_entry.idle_stamp == '0) begin
                  state_ff <= (addr_ff == LAST_IDX) ? ST_SW_FIN : ST_SW_RD;
               end else begin
                  state_ff <= ST_SW_TMO;
               end
            end
            ST_SW_TMO: begin
               if (!alu_neg) begin
                  valid_ff[addr_ff] <= 1'b0;
                  count_ff          <= count_ff - CNT_W'(1);
                  state_ff          <= (addr_ff == LAST_IDX) ? ST_SW_FIN : ST_SW_RD;
               end else begin
                  state_ff <= ST_SW_MAX;
               end
            end
            ST_SW_MAX: begin
               state_ff <= (addr_ff == LAST_IDX) ? ST_SW_FIN : ST_SW_RD;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Working and output registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cap_ff     <= req_capacity_bps;
               unl_ff     <= req_capacity_unlimited;
               bw_ff      <= req_bandwidth_bps;
               now_ff     <= req_now_ms;
               longest_ff <= '1;
               addr_ff    <= (req_type == cbat_pkg::REQ_SWEEP) ? '0 :
                             req_client_id[IDX_W-1:0];
            end
         end
         ST_RS_SUM: begin
            acc_ff  <= alu_res;
            cons_ff <= cur_valid ? rd_entry.consumed : '0;
            act_ff  <= cur_valid ? rd_entry.active : '0;
         end
         ST_RS_CMP: begin
            if (out_free) begin
               status_ff      <= rs_grant ? cbat_pkg::STATUS_DONE :
                                 cbat_pkg::STATUS_EXCEEDED;
               out_cons_ff    <= rs_cons;
               out_act_ff     <= rs_act;
               out_cap_ff     <= cap_ff;
               out_longest_ff <= '0;
               out_next_ff    <= '0;
               out_count_ff   <= cur_valid ? count_ff : count_ff + CNT_W'(1);
            end
         end
         ST_RL_SUB: begin
            if (out_free) begin
               status_ff      <= cur_valid ? cbat_pkg::STATUS_DONE :
                                 cbat_pkg::STATUS_UNKNOWN;
               out_cons_ff    <= cur_valid ? rl_cons : '0;
               out_act_ff     <= cur_valid ? rl_act : '0;
               out_cap_ff     <= cur_valid ? rd_entry.capacity : '0;
               out_longest_ff <= '0;
               out_next_ff    <= '0;
               out_count_ff   <= count_ff;
            end
         end
         ST_SW_IDLE: begin
            acc_ff <= alu_res;
            if (!cur_valid || rd_entry.idle_stamp == '0) begin
               addr_ff <= addr_ff + IDX_W'(1);
            end
         end
         ST_SW_TMO: begin
            if (!alu_neg) begin
               addr_ff <= addr_ff + IDX_W'(1);
            end
         end
         ST_SW_MAX: begin
            // Keep the larger idle time; ties leave it as is.
            if (!alu_neg && alu_res != '0) begin
               longest_ff <= sweep_idle;
            end
            addr_ff <= addr_ff + IDX_W'(1);
         end
         ST_SW_FIN: begin
            if (out_free) begin
               status_ff      <= cbat_pkg::STATUS_SWEEP_DONE;
               out_cons_ff    <= '0;
               out_act_ff     <= '0;
               out_cap_ff     <= '0;
               out_longest_ff <= longest_ff;
               out_next_ff    <= longest_pos ? alu_res[VAL_W-1:0] : dflt_ff;
               out_count_ff   <= count_ff;
            end
         end
         ST_NOP: begin
            if (out_free) begin
               status_ff      <= cbat_pkg::STATUS_DONE;
               out_cons_ff    <= '0;
               out_act_ff     <= '0;
               out_cap_ff     <= '0;
               out_longest_ff <= '0;
               out_next_ff    <= '0;
               out_count_ff   <= count_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = status_ff;
   assign rsp_consumed_bps        = out_cons_ff;
   assign rsp_active_transfers    = out_act_ff;
   assign rsp_client_capacity_bps = out_cap_ff;
   assign rsp_longest_idle_ms     = out_longest_ff;
   assign rsp_next_check_ms       = out_next_ff;
   assign rsp_client_count        = out_count_ff;

   `ASSERT_CLK(a_count_matches_valid, clock, reset,
      count_ff == CNT_W'($countones(valid_ff)))
   `ASSERT_CLK(a_reserve_makes_valid, clock, reset,
      (state_ff == ST_RS_CMP && out_free) |=> valid_ff[addr_ff])
   `ASSERT_CLK(a_sweep_rsp_no_entry, clock, reset,
      (rsp_valid_ff && status_ff == cbat_pkg::STATUS_SWEEP_DONE) |->
         (out_cons_ff == '0 && out_act_ff == '0 && out_cap_ff == '0))
   `ASSERT_CLK(a_longest_floor, clock, reset, longest_ff[IDLE_W-1] |-> (&longest_ff))

endmodule
